// ===== sv/p2c_pkg.sv =====
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared types, codes and helpers of the planar to chunky palette unit.
// ----------------------------------------------------------------------------
package p2c_pkg;

   // Palette and configuration port geometry
   localparam int PALETTE_ENTRIES = 8;
   localparam int PAIR_COUNT      = PALETTE_ENTRIES / 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;

   // Internal widths, fixed by the field widths
   localparam int PS_W    = 15;   // bytes_per_row * image_height
   localparam int ROW_W   = 15;   // pixel_y * bytes_per_row + pixel_x / 8
   localparam int OFF_W   = 20;   // store offsets and required byte count
   localparam int PLANE_W = 4;    // plane count, up to eight
   localparam int IDX_W   = 3;    // palette index

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_PLANE_COUNT   = 3'd2,
      CSR_BYTES_PER_ROW = 3'd3,
      CSR_PALETTE_0     = 3'd4,
      CSR_PALETTE_1     = 3'd5,
      CSR_PALETTE_2     = 3'd6,
      CSR_PALETTE_3     = 3'd7
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_PIXEL = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       first_byte;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic       darken;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic [1:0]  status;
   } rsp_type;

   // Classified item as it travels through the queue
   typedef struct packed {
      logic             is_pixel;
      logic [7:0]       data_byte;
      logic             first_byte;
      logic [2:0]       x_bit;
      logic [ROW_W-1:0] row_off;
      logic             coord_bad;
      logic             darken;
   } cmd_type;

   // Configuration as seen by the back end
   typedef struct packed {
      logic [PAIR_COUNT-1:0][63:0] palette;
      logic [PS_W-1:0]             plane_span;
      logic [OFF_W-1:0]            required;
      logic [PLANE_W-1:0]          planes;
   } cfg_view_type;

   // Queue status as seen by the front end and the back end
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Tag that follows a pair of store reads
   typedef struct packed {
      logic               valid;
      logic [PLANE_W-1:0] plane;
      logic               use0;
      logic               use1;
   } meta_type;

   typedef enum logic [1:0] {
      BACK_IDLE  = 2'd0,
      BACK_READ  = 2'd1,
      BACK_DRAIN = 2'd2
   } back_state_type;

   // floor(c * 4 / 5) for an 8-bit channel: 4/5 ~= 820/1024, exact below 256
   function automatic logic [7:0] p2c_scale45(input logic [7:0] c);
      logic [17:0] prod;
      prod = 18'(c) * 18'd820;
      return prod[17:10];
   endfunction

   // Scale RGB to four fifths unless the pixel is fully transparent
   function automatic logic [31:0] p2c_darken(input logic [31:0] p);
      logic [31:0] res;
      if (p[31:24] == 8'h00) begin
         res = p;
      end else begin
         res = {p[31:24], p2c_scale45(p[23:16]), p2c_scale45(p[15:8]),
                p2c_scale45(p[7:0])};
      end
      return res;
   endfunction

endpackage

// ===== sv/p2c_ram.sv =====
// ----------------------------------------------------------------------------
// p2c_ram
// Generic single write, dual read RAM with registered read data.
// ----------------------------------------------------------------------------
module p2c_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ===== sv/p2c_queue.sv =====
// ----------------------------------------------------------------------------
// p2c_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module p2c_queue
   import p2c_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output queue_status_type stat,
   output cmd_type          head
);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

// ===== sv/p2c_front.sv =====
// ----------------------------------------------------------------------------
// p2c_front
// Configuration registers, item intake and classification into commands.
// ----------------------------------------------------------------------------
module p2c_front
   import p2c_pkg::*;
#(
   parameter int MAX_PLANES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  req_type                req_item,
   output logic                   busy,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  queue_status_type       q_stat,
   output logic                   q_push,
   output cmd_type                q_data,
   output cfg_view_type           cfg
);

   logic [8:0]                  width_ff;
   logic [8:0]                  height_ff;
   logic [PLANE_W-1:0]          plane_count_ff;
   logic [5:0]                  bpr_ff;
   logic [PAIR_COUNT-1:0][63:0] palette_ff;
   logic [PS_W-1:0]             plane_span_ff, plane_span_in;
   logic [OFF_W-1:0]            required_ff, required_in;
   logic [PLANE_W-1:0]          planes_sat;
   logic                        front_valid_ff, front_valid_in;
   req_type                     front_item_ff, front_item_in;
   logic                        accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= '0;
         height_ff      <= '0;
         plane_count_ff <= '0;
         bpr_ff         <= '0;
         palette_ff     <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   width_ff       <= csr_wdata[8:0];
            CSR_IMAGE_HEIGHT:  height_ff      <= csr_wdata[8:0];
            CSR_PLANE_COUNT:   plane_count_ff <= csr_wdata[PLANE_W-1:0];
            CSR_BYTES_PER_ROW: bpr_ff         <= csr_wdata[5:0];
            CSR_PALETTE_0:     palette_ff[0]  <= csr_wdata;
            CSR_PALETTE_1:     palette_ff[1]  <= csr_wdata;
            CSR_PALETTE_2:     palette_ff[2]  <= csr_wdata;
            CSR_PALETTE_3:     palette_ff[3]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // derived geometry, one multiply per stage
   assign planes_sat = (plane_count_ff > PLANE_W'(MAX_PLANES)) ?
                       PLANE_W'(MAX_PLANES) : plane_count_ff;
   assign plane_span_in = PS_W'(bpr_ff) * PS_W'(height_ff);
   assign required_in   = OFF_W'(plane_span_ff) * OFF_W'(planes_sat);

   always_ff @(posedge clock) begin
      plane_span_ff <= plane_span_in;
      required_ff   <= required_in;
   end

   assign cfg.palette    = palette_ff;
   assign cfg.plane_span = plane_span_ff;
   assign cfg.required   = required_ff;
   assign cfg.planes     = planes_sat;

   // intake stage: holds one item until the queue has room
   assign busy   = front_valid_ff && q_stat.full;
   assign accept = start && !busy;
   assign q_push = front_valid_ff && !q_stat.full;

   always_comb begin
      front_valid_in = accept || (front_valid_ff && !q_push);
      front_item_in  = accept ? req_item : front_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

   // classify: row offset within a plane and coordinate range check
   always_comb begin
      q_data.is_pixel   = (front_item_ff.mode == MODE_PIXEL);
      q_data.data_byte  = front_item_ff.data_byte;
      q_data.first_byte = front_item_ff.first_byte;
      q_data.x_bit      = front_item_ff.pixel_x[2:0];
      q_data.row_off    = ROW_W'(front_item_ff.pixel_y) * ROW_W'(bpr_ff)
                        + ROW_W'(front_item_ff.pixel_x[7:3]);
      q_data.coord_bad  = ({1'b0, front_item_ff.pixel_x} >= width_ff) ||
                          ({1'b0, front_item_ff.pixel_y} >= height_ff);
      q_data.darken     = front_item_ff.darken;
   end

endmodule

// ===== sv/p2c_back.sv =====
// ----------------------------------------------------------------------------
// p2c_back
// Executes commands: stores plane bytes, gathers pixel bits two planes per
// cycle, looks up the palette and optionally darkens the result.
// ----------------------------------------------------------------------------
module p2c_back
   import p2c_pkg::*;
#(
   parameter int STORE_BYTES = 8192
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  cmd_type          q_head,
   output logic             q_pop,
   input  cfg_view_type     cfg,
   output logic             rsp_valid,
   output rsp_type          rsp_item
);

   localparam int AW    = $clog2(STORE_BYTES);
   localparam int CNT_W = $clog2(STORE_BYTES + 1);

   back_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [PLANE_W-1:0]  plane_ff, plane_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                bad_ff, bad_in;
   logic [2:0]          x_bit_ff, x_bit_in;
   logic                darken_ff, darken_in;
   meta_type            meta_ff, meta_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_item_ff, rsp_item_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr0, rd_addr1;
   logic [7:0]          rd_data0, rd_data1;

   logic [OFF_W-1:0]    count_ext, off1;
   logic [PLANE_W-1:0]  plane_p1, meta_p1;
   logic                use0, use1, last_pair, short_data;
   logic [2:0]          bit_sel;
   logic [IDX_W-1:0]    gather, idx_next;
   logic [63:0]         pair;
   logic [31:0]         pix, pix_out;

   p2c_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (q_head.data_byte),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // offsets and plane bookkeeping for the current read pair
   assign count_ext  = OFF_W'(count_ff);
   assign off1       = off_ff + OFF_W'(cfg.plane_span);
   assign plane_p1   = plane_ff + PLANE_W'(1);
   assign use0       = plane_ff < cfg.planes;
   assign use1       = plane_p1 < cfg.planes;
   assign last_pair  = ({1'b0, plane_ff} + (PLANE_W+1)'(2)) >= {1'b0, cfg.planes};
   assign short_data = count_ext < cfg.required;
   assign rd_addr0   = off_ff[AW-1:0];
   assign rd_addr1   = off1[AW-1:0];

   // bit gather from the pair read in the previous cycle
   assign bit_sel = 3'd7 - x_bit_ff;
   assign meta_p1 = meta_ff.plane + PLANE_W'(1);

   always_comb begin
      for (int i = 0; i < IDX_W; i++) begin
         gather[i] = meta_ff.valid &&
                     ((meta_ff.use0 && meta_ff.plane == PLANE_W'(i) && rd_data0[bit_sel]) ||
                      (meta_ff.use1 && meta_p1 == PLANE_W'(i) && rd_data1[bit_sel]));
      end
   end

   assign idx_next = idx_ff | gather;

   // palette lookup and optional darkening
   assign pair    = cfg.palette[idx_next[IDX_W-1:1]];
   assign pix     = idx_next[0] ? pair[63:32] : pair[31:0];
   assign pix_out = darken_ff ? p2c_darken(pix) : pix;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      off_in       = off_ff;
      plane_in     = plane_ff;
      idx_in       = idx_next;
      bad_in       = bad_ff;
      x_bit_in     = x_bit_ff;
      darken_in    = darken_ff;
      meta_in      = '0;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];

      case (state_ff)
         BACK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               if (!q_head.is_pixel) begin
                  // byte load: restart, append or drop when full
                  if (q_head.first_byte) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     count_in = CNT_W'(1);
                  end else if (count_ff != CNT_W'(STORE_BYTES)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (short_data) begin
                  rsp_valid_in           = 1'b1;
                  rsp_item_in.pixel_argb = '0;
                  rsp_item_in.status     = STATUS_SHORT;
               end else if (q_head.coord_bad) begin
                  rsp_valid_in           = 1'b1;
                  rsp_item_in.pixel_argb = '0;
                  rsp_item_in.status     = STATUS_RANGE;
               end else begin
                  off_in    = OFF_W'(q_head.row_off);
                  plane_in  = '0;
                  idx_in    = '0;
                  bad_in    = 1'b0;
                  x_bit_in  = q_head.x_bit;
                  darken_in = q_head.darken;
                  state_in  = BACK_READ;
               end
            end
         end
         BACK_READ: begin
            // two planes per cycle; any needed byte past the loaded data is short
            meta_in.valid = 1'b1;
            meta_in.plane = plane_ff;
            meta_in.use0  = use0;
            meta_in.use1  = use1;
            bad_in = bad_ff || (use0 && off_ff >= count_ext) ||
                     (use1 && off1 >= count_ext);
            off_in   = off1 + OFF_W'(cfg.plane_span);
            plane_in = plane_ff + PLANE_W'(2);
            if (last_pair) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            rsp_valid_in           = 1'b1;
            rsp_item_in.pixel_argb = bad_ff ? 32'h0 : pix_out;
            rsp_item_in.status     = bad_ff ? STATUS_SHORT : STATUS_OK;
            state_in               = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         meta_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         meta_ff      <= meta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff      <= off_in;
      plane_ff    <= plane_in;
      idx_ff      <= idx_in;
      bad_ff      <= bad_in;
      x_bit_ff    <= x_bit_in;
      darken_ff   <= darken_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== sv/planar_to_chunky_palette_unit.sv =====
// ----------------------------------------------------------------------------
// planar_to_chunky_palette_unit
// Planar bitmap store with per-pixel palette lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req_item when start is high and busy is low. A load item
//   (mode 0) appends data_byte to the plane store, first_byte restarting at
//   offset zero; it gives no result. A pixel item (mode 1) gives one result
//   on rsp_item, marked by rsp_valid for exactly one cycle.
//   Configuration is written through csr_write_en / csr_index / csr_wdata
//   while no item is in flight.
//   With the back end idle, a load passes the intake register and the queue
//   before it is written to the store; a pixel request with a short-data or
//   range error is answered from the queue head, a good one after its read
//   pairs and a drain state, each through a result register.
//   The back end handles a load or error in its idle state as it pops it, and
//   reads a good pixel's planes two at a time through the two read ports of
//   the plane store; it pops no new item until it has formed that pixel's
//   result. A two-entry queue lets intake run ahead.
//   Reset clears the configuration registers, the load count and the queue;
//   the store contents stay undefined until written. Results cannot be
//   stalled.
// ----------------------------------------------------------------------------
module planar_to_chunky_palette_unit
   import p2c_pkg::*;
#(
   parameter int STORE_BYTES = 8192,
   parameter int MAX_PLANES  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  req_type                req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output rsp_type                rsp_item,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   queue_status_type q_stat;
   logic             q_push;
   logic             q_pop;
   cmd_type          q_data;
   cmd_type          q_head;
   cfg_view_type     cfg;

   p2c_front #(
      .MAX_PLANES (MAX_PLANES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_item     (req_item),
      .busy         (busy),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_stat       (q_stat),
      .q_push       (q_push),
      .q_data       (q_data),
      .cfg          (cfg)
   );

   p2c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .stat      (q_stat),
      .head      (q_head)
   );

   p2c_back #(
      .STORE_BYTES (STORE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== sv/p2c_checker.sv =====
// ----------------------------------------------------------------------------
// p2c_checker
// Port-level checks of the planar to chunky palette unit.
// ----------------------------------------------------------------------------
module p2c_checker
   import p2c_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // no result right after reset
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // intake open right after reset
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !busy)
      else $error("busy right after reset");

   // busy only rises when an item was just taken
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted item");

   // error results carry a zero pixel
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != STATUS_OK) |-> rsp_item.pixel_argb == 32'h0)
      else $error("error result with nonzero pixel");

endmodule

bind planar_to_chunky_palette_unit p2c_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
